// ===== hw/rtl/lfu_pkg.sv =====
// Shared constants and controller/datapath handshake types for the LFU page replacement block.
package lfu_pkg;

	localparam int FRAMES_DEF     = 8;
	localparam int PAGE_BITS_DEF  = 10;
	localparam int COUNT_BITS_DEF = 16;

	localparam int LIMIT_W = 4;
	localparam int TALLY_W = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

	typedef struct packed {
		logic clear_step;
		logic load;
		logic look;
		logic scan_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic full;
		logic scan_last;
	} stat_t;

endpackage

// ===== hw/rtl/lfu_req_if.sv =====
// Request channel: one page reference per handshake.
interface lfu_req_if #(
	parameter int PAGE_BITS = lfu_pkg::PAGE_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page;

	modport source (output valid, output page, input ready);
	modport sink (input valid, input page, output ready);
endinterface

// ===== hw/rtl/lfu_rsp_if.sv =====
// Result channel: hit/fault outcome, victim and running totals for each request.
interface lfu_rsp_if #(
	parameter int PAGE_BITS = lfu_pkg::PAGE_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic                       was_hit;
	logic                       evicted;
	logic [PAGE_BITS-1:0]       victim_page;
	logic [lfu_pkg::TALLY_W-1:0] hits_so_far;
	logic [lfu_pkg::TALLY_W-1:0] faults_so_far;

	modport source (output valid, output was_hit, output evicted, output victim_page,
		output hits_so_far, output faults_so_far, input ready);
	modport sink (input valid, input was_hit, input evicted, input victim_page,
		input hits_so_far, input faults_so_far, output ready);
endinterface

// ===== hw/rtl/lfu_page_replacement.sv =====
// LFU page replacement block: top level joining the sequencer and the datapath.
// Each request goes through accept, lookup and commit while the frame list still has
// room; once it is full, a scan sits between lookup and commit, in which the use counts
// of the resident frames are scanned one frame per cycle to find the victim. The result
// sits in an output register, so the next request is taken while it waits; a request
// only stalls at commit if the previous result is still unread. After reset the history
// memory is cleared one entry per cycle, and requests are held off until all 2**PAGE_BITS
// entries (1024 by default) are cleared; the frame limit may be written at any time while
// no request is in flight.
module lfu_page_replacement #(
	parameter int FRAMES     = lfu_pkg::FRAMES_DEF,
	parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lfu_pkg::LIMIT_W-1:0] cfg_wdata,
	lfu_req_if.sink                     req,
	lfu_rsp_if.source                   rsp
);

	lfu_pkg::cmd_t  cmd;
	lfu_pkg::stat_t stat;

	lfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lfu_datapath #(
		.FRAMES     (FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_page       (req.page),
		.cmd           (cmd),
		.stat          (stat),
		.was_hit       (rsp.was_hit),
		.evicted       (rsp.evicted),
		.victim_page   (rsp.victim_page),
		.hits_so_far   (rsp.hits_so_far),
		.faults_so_far (rsp.faults_so_far)
	);

`ifndef ASSERT_OFF
	// A hit never evicts.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.was_hit && rsp.evicted))
		else $error("hit reported together with an eviction");

	// Without an eviction the victim field reads zero.
	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.evicted) |-> (rsp.victim_page == '0))
		else $error("victim page set without an eviction");

	// Only one request is in flight: ready drops right after an accept.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in flight");

	// A commit always presents a result on the next cycle.
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp.valid)
		else $error("commit without a result");
`endif

endmodule

// ===== hw/rtl/lfu_datapath.sv =====
// Frame list, history memory, scan unit and tallies of the LFU page replacement block.
module lfu_datapath #(
	parameter int FRAMES     = lfu_pkg::FRAMES_DEF,
	parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lfu_pkg::LIMIT_W-1:0]   cfg_wdata,
	input  logic [PAGE_BITS-1:0]          in_page,
	input  lfu_pkg::cmd_t                 cmd,
	output lfu_pkg::stat_t                stat,
	output logic                          was_hit,
	output logic                          evicted,
	output logic [PAGE_BITS-1:0]          victim_page,
	output logic [lfu_pkg::TALLY_W-1:0]   hits_so_far,
	output logic [lfu_pkg::TALLY_W-1:0]   faults_so_far
);

	localparam int IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W      = $clog2(FRAMES + 1);
	localparam int CMP_W      = (CNT_W > lfu_pkg::LIMIT_W) ? CNT_W : lfu_pkg::LIMIT_W;
	localparam int HIST_DEPTH = 1 << PAGE_BITS;

	localparam logic [COUNT_BITS-1:0]      COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [lfu_pkg::TALLY_W-1:0] TALLY_MAX = {lfu_pkg::TALLY_W{1'b1}};

	logic [lfu_pkg::LIMIT_W-1:0] limit_q;
	logic [PAGE_BITS-1:0]        slot_page_q [FRAMES];
	logic [COUNT_BITS-1:0]       slot_uses_q [FRAMES];
	logic [CNT_W-1:0]            rt_q;

	logic [COUNT_BITS-1:0] hist_mem [HIST_DEPTH];
	logic [COUNT_BITS-1:0] hist_rd_q;
	logic [PAGE_BITS-1:0]  clr_addr_q;

	logic [PAGE_BITS-1:0]  page_q;
	logic                  found_q;
	logic [IDX_W-1:0]      pos_q;
	logic                  full_q;
	logic [IDX_W-1:0]      scan_idx_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [COUNT_BITS-1:0] best_uses_q;
	logic [PAGE_BITS-1:0]  best_page_q;
	logic [COUNT_BITS-1:0] hit_uses_q;

	logic [lfu_pkg::TALLY_W-1:0] hit_tally_q;
	logic [lfu_pkg::TALLY_W-1:0] fault_tally_q;
	logic                        was_hit_q;
	logic                        evicted_q;
	logic [PAGE_BITS-1:0]        victim_q;

	logic                        found;
	logic [IDX_W-1:0]            pos;
	logic                        full;
	logic [lfu_pkg::LIMIT_W-1:0] limit_nz;
	logic [COUNT_BITS-1:0]       cur_uses;
	logic [PAGE_BITS-1:0]        cur_page;
	logic [COUNT_BITS-1:0]       hist_inc;
	logic                        hist_we;
	logic [COUNT_BITS-1:0]       new_uses;
	logic [IDX_W-1:0]            drop_idx;
	logic                        miss_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lfu_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Parallel tag compare; pages in the list are distinct, so at most one lane matches.
	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if ((CNT_W'(i) < rt_q) && (slot_page_q[i] == page_q)) begin
				found = 1'b1;
				pos   = pos | IDX_W'(i);
			end
		end
	end

	// A limit of zero behaves as one; the FRAMES test caps the limit at the built size.
	assign limit_nz = (limit_q == '0) ? lfu_pkg::LIMIT_W'(1) : limit_q;
	assign full     = (CMP_W'(rt_q) >= CMP_W'(limit_nz)) || (rt_q == CNT_W'(FRAMES));

	assign cur_uses = slot_uses_q[scan_idx_q];
	assign cur_page = slot_page_q[scan_idx_q];

	assign hist_inc  = (hist_rd_q == COUNT_MAX) ? COUNT_MAX : hist_rd_q + COUNT_BITS'(1);
	assign miss_full = full_q && !found_q;
	assign hist_we   = !full_q || (hist_rd_q != '0);
	assign drop_idx  = found_q ? pos_q : best_idx_q;
	assign new_uses  = found_q ? ((hit_uses_q == COUNT_MAX) ? COUNT_MAX
		: hit_uses_q + COUNT_BITS'(1)) : hist_inc;

	assign stat.clear_last = (clr_addr_q == {PAGE_BITS{1'b1}});
	assign stat.full       = full;
	assign stat.scan_last  = (CNT_W'(scan_idx_q) == rt_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_addr_q <= clr_addr_q + PAGE_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			hist_mem[clr_addr_q] <= '0;
		end else if (cmd.commit && hist_we) begin
			hist_mem[page_q] <= hist_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hist_rd_q <= hist_mem[in_page];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= in_page;
		end
		if (cmd.look) begin
			found_q    <= found;
			pos_q      <= pos;
			full_q     <= full;
			scan_idx_q <= '0;
		end else if (cmd.scan_step) begin
			if ((scan_idx_q == '0) || (cur_uses < best_uses_q)) begin
				best_idx_q  <= scan_idx_q;
				best_uses_q <= cur_uses;
				best_page_q <= cur_page;
			end
			if (scan_idx_q == pos_q) begin
				hit_uses_q <= cur_uses;
			end
			scan_idx_q <= scan_idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_q <= '0;
		end else if (cmd.commit && !full_q && !found_q) begin
			rt_q <= rt_q + CNT_W'(1);
		end
	end

	// Once full, a commit drops the chosen lane and appends at the tail in one step.
	for (genvar i = 0; i < FRAMES; i++) begin : g_lane
		logic [PAGE_BITS-1:0]  next_page;
		logic [COUNT_BITS-1:0] next_uses;

		if (i < FRAMES - 1) begin : g_shift
			assign next_page = slot_page_q[i+1];
			assign next_uses = slot_uses_q[i+1];
		end else begin : g_end
			assign next_page = slot_page_q[i];
			assign next_uses = slot_uses_q[i];
		end

		always_ff @(posedge clk) begin
			if (cmd.commit) begin
				if (!full_q) begin
					if (found_q && (pos_q == IDX_W'(i))) begin
						if (slot_uses_q[i] != COUNT_MAX) begin
							slot_uses_q[i] <= slot_uses_q[i] + COUNT_BITS'(1);
						end
					end else if (!found_q && (rt_q == CNT_W'(i))) begin
						slot_page_q[i] <= page_q;
						slot_uses_q[i] <= COUNT_BITS'(1);
					end
				end else if (CNT_W'(i + 1) == rt_q) begin
					slot_page_q[i] <= page_q;
					slot_uses_q[i] <= new_uses;
				end else if ((IDX_W'(i) >= drop_idx) && (CNT_W'(i + 1) < rt_q)) begin
					slot_page_q[i] <= next_page;
					slot_uses_q[i] <= next_uses;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_tally_q   <= '0;
			fault_tally_q <= '0;
		end else if (cmd.commit) begin
			if (found_q) begin
				if (hit_tally_q != TALLY_MAX) begin
					hit_tally_q <= hit_tally_q + lfu_pkg::TALLY_W'(1);
				end
			end else if (fault_tally_q != TALLY_MAX) begin
				fault_tally_q <= fault_tally_q + lfu_pkg::TALLY_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			was_hit_q <= found_q;
			evicted_q <= miss_full;
			victim_q  <= miss_full ? best_page_q : '0;
		end
	end

	assign was_hit       = was_hit_q;
	assign evicted       = evicted_q;
	assign victim_page   = victim_q;
	assign hits_so_far   = hit_tally_q;
	assign faults_so_far = fault_tally_q;

endmodule

// ===== hw/rtl/lfu_ctrl.sv =====
// Sequencer of the LFU page replacement block: clearing pass, lookup, scan and commit.
module lfu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  lfu_pkg::stat_t stat,
	output lfu_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	assign cmd.clear_step = (state_q == ST_CLEAR);
	assign cmd.load       = (state_q == ST_IDLE) && req_valid;
	assign cmd.look       = (state_q == ST_LOOK);
	assign cmd.scan_step  = (state_q == ST_SCAN);
	assign cmd.commit     = (state_q == ST_UPDATE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					if (stat.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= stat.full ? ST_SCAN : ST_UPDATE;
				end
				ST_SCAN: begin
					if (stat.scan_last) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
